// File: rtl/core/ipv4dq_pkg.sv
// Package with the beat types and character constants of the dotted-quad parser.
`timescale 1ns / 1ps
`default_nettype none

package ipv4dq_pkg;

   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [9:0] FIELD_MAX   = 10'd255;
   localparam logic [1:0] DIGITS_MAX  = 2'd3;
   localparam logic [2:0] DOTS_NEEDED = 3'd3;

   typedef struct packed {
      logic       char_present;
      logic [7:0] char_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic        address_ok;
      logic [31:0] address_value;
      logic        mask_ok;
      logic [5:0]  prefix_bits;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/ipv4_dotted_quad_parser_top.sv
// Top level of the strict dotted-decimal IPv4 parser with netmask check.
//
//   channel  | direction | handshake              | payload
//   req_     | in        | req_valid / req_ready  | ipv4dq_pkg::req_type
//   rsp_     | out       | rsp_valid / rsp_ready  | ipv4dq_pkg::rsp_type
//
// One character beat is taken every cycle unless an end beat is held in the input
// register by a full result slot; an end beat's result is registered as it leaves.
// The per-character step (multiply by ten, add, compare with 255) and the mask
// check on the end beat sit between the input register and the result register.
// Reset clears the parser state and both valid flags; the string restarts empty.
// A stalled result only holds back beats once an end beat is waiting behind it.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_dotted_quad_parser_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  ipv4dq_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output ipv4dq_pkg::rsp_type rsp_data
);

   // Input register
   logic                in_valid_ff, in_valid_in;
   ipv4dq_pkg::req_type in_data_ff;

   // Parser state
   logic [9:0]  field_value_ff, field_value_in;
   logic [1:0]  digit_count_ff, digit_count_in;
   logic [2:0]  field_count_ff, field_count_in;
   logic [31:0] address_shift_ff, address_shift_in;
   logic        error_seen_ff, error_seen_in;
   logic        last_was_dot_ff, last_was_dot_in;
   logic        any_char_seen_ff, any_char_seen_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   ipv4dq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        advance;
   logic        is_digit;
   logic [9:0]  field_times_ten;
   logic        end_ok;
   logic [31:0] end_addr;
   logic [31:0] end_inv;
   logic [31:0] end_inv_inc;
   logic        end_contig;
   logic [5:0]  end_ones;

   // The stored beat moves on unless it is an end beat and the result slot is full.
   assign advance   = in_valid_ff &&
                      (!in_data_ff.end_of_text || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   assign is_digit = (in_data_ff.char_byte >= ipv4dq_pkg::CHAR_ZERO) &&
                     (in_data_ff.char_byte <= ipv4dq_pkg::CHAR_NINE);
   assign field_times_ten = {field_value_ff[6:0], 3'b000} + {field_value_ff[8:0], 1'b0};

   always_comb begin
      field_value_in   = field_value_ff;
      digit_count_in   = digit_count_ff;
      field_count_in   = field_count_ff;
      address_shift_in = address_shift_ff;
      error_seen_in    = error_seen_ff;
      last_was_dot_in  = last_was_dot_ff;
      any_char_seen_in = any_char_seen_ff;

      if (in_data_ff.char_present) begin
         any_char_seen_in = 1'b1;
         if (!error_seen_ff) begin
            if (in_data_ff.char_byte == ipv4dq_pkg::CHAR_DOT) begin
               if (digit_count_ff == 2'd0 || field_count_ff >= ipv4dq_pkg::DOTS_NEEDED ||
                   field_value_ff > ipv4dq_pkg::FIELD_MAX) begin
                  error_seen_in = 1'b1;
               end else begin
                  address_shift_in = {address_shift_ff[23:0], field_value_ff[7:0]};
                  field_count_in   = field_count_ff + 3'd1;
                  field_value_in   = '0;
                  digit_count_in   = '0;
                  last_was_dot_in  = 1'b1;
               end
            end else if (is_digit) begin
               if (digit_count_ff >= ipv4dq_pkg::DIGITS_MAX) begin
                  error_seen_in = 1'b1;
               end else begin
                  field_value_in  = field_times_ten +
                                    {6'd0, in_data_ff.char_byte[3:0]};
                  digit_count_in  = digit_count_ff + 2'd1;
                  last_was_dot_in = 1'b0;
               end
            end else begin
               error_seen_in = 1'b1;
            end
         end
      end

      // End-of-string evaluation on the state after this beat's character.
      end_ok = !error_seen_in && any_char_seen_in && !last_was_dot_in &&
               digit_count_in != 2'd0 && field_count_in == ipv4dq_pkg::DOTS_NEEDED &&
               field_value_in <= ipv4dq_pkg::FIELD_MAX;
      end_addr    = {address_shift_in[23:0], field_value_in[7:0]};
      end_inv     = ~end_addr;
      end_inv_inc = end_inv + 32'd1;
      end_contig  = (end_inv & end_inv_inc) == 32'd0;
      // With contiguous ones from the top the prefix is just the population count.
      end_ones    = 6'($countones(end_addr));

      rsp_data_in.address_ok    = end_ok;
      rsp_data_in.address_value = end_ok ? end_addr : 32'd0;
      rsp_data_in.mask_ok       = end_ok && end_contig && end_ones != 6'd0;
      rsp_data_in.prefix_bits   = rsp_data_in.mask_ok ? end_ones : 6'd0;

      if (in_data_ff.end_of_text) begin
         field_value_in   = '0;
         digit_count_in   = '0;
         field_count_in   = '0;
         address_shift_in = '0;
         error_seen_in    = 1'b0;
         last_was_dot_in  = 1'b0;
         any_char_seen_in = 1'b0;
      end
   end

   assign rsp_valid_in = (advance && in_data_ff.end_of_text) ||
                         (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         field_value_ff   <= '0;
         digit_count_ff   <= '0;
         field_count_ff   <= '0;
         address_shift_ff <= '0;
         error_seen_ff    <= 1'b0;
         last_was_dot_ff  <= 1'b0;
         any_char_seen_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            field_value_ff   <= field_value_in;
            digit_count_ff   <= digit_count_in;
            field_count_ff   <= field_count_in;
            address_shift_ff <= address_shift_in;
            error_seen_ff    <= error_seen_in;
            last_was_dot_ff  <= last_was_dot_in;
            any_char_seen_ff <= any_char_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && in_data_ff.end_of_text) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A netmask is only ever reported for a valid address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.mask_ok || rsp_data_ff.address_ok))
      else $error("mask_ok raised for an invalid address");

   // An invalid string gives an all-zero result.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.address_ok) |->
      (rsp_data_ff.address_value == 32'd0 && rsp_data_ff.prefix_bits == 6'd0))
      else $error("invalid string left non-zero result fields");

   // A reported mask has a prefix between one and thirty-two.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.mask_ok) |->
      (rsp_data_ff.prefix_bits != 6'd0 && rsp_data_ff.prefix_bits <= 6'd32))
      else $error("mask prefix out of range");

   // Once an end beat has moved on, the parser starts the next string empty.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.end_of_text) |=>
      (field_count_ff == 3'd0 && digit_count_ff == 2'd0 && !error_seen_ff &&
       !any_char_seen_ff))
      else $error("parser state not cleared after end of string");

   // The field count never passes the number of separating dots.
   assert property (@(posedge clock) disable iff (reset)
      field_count_ff <= ipv4dq_pkg::DOTS_NEEDED)
      else $error("field count overran");

endmodule

`default_nettype wire

// File: tb/ipv4_dotted_quad_parser_top_test.sv
// Self-checking testbench for the dotted-quad IPv4 parser with netmask check.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_top_test;
   import ipv4dq_pkg::*;

   localparam int ITEM_TARGET  = 1150;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {FLAW_NONE, FLAW_OVER_RANGE, FLAW_FOUR_DIGITS, FLAW_EMPTY} flaw_type;

   // Tracks the parse of the current string and queues the result of every end beat.
   class quad_scoreboard;
      logic [9:0]  field_val;
      logic [1:0]  digit_cnt;
      logic [2:0]  dot_cnt;
      logic [31:0] addr_acc;
      bit          bad_text;
      bit          after_dot;
      bit          got_char;
      rsp_type     pending_q[$];
      int          mismatches;
      int          results;
      int          good_addresses;
      int          good_masks;

      function new();
         restart();
      endfunction

      function void restart();
         field_val = '0;
         digit_cnt = '0;
         dot_cnt   = '0;
         addr_acc  = '0;
         bad_text  = 1'b0;
         after_dot = 1'b0;
         got_char  = 1'b0;
      endfunction

      function void take_char(logic [7:0] c);
         got_char = 1'b1;
         if (bad_text) return;
         if (c == CHAR_DOT) begin
            if (digit_cnt == 2'd0 || dot_cnt >= DOTS_NEEDED || field_val > FIELD_MAX) begin
               bad_text = 1'b1;
            end else begin
               addr_acc  = {addr_acc[23:0], field_val[7:0]};
               dot_cnt   = dot_cnt + 3'd1;
               field_val = '0;
               digit_cnt = '0;
               after_dot = 1'b1;
            end
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (digit_cnt >= DIGITS_MAX) begin
               bad_text = 1'b1;
            end else begin
               field_val = field_val * 10'd10 + 10'(c - CHAR_ZERO);
               digit_cnt = digit_cnt + 2'd1;
               after_dot = 1'b0;
            end
         end else begin
            bad_text = 1'b1;
         end
      endfunction

      function void note_request(req_type beat);
         rsp_type     res;
         logic [31:0] inv;
         if (beat.char_present) take_char(beat.char_byte);
         if (!beat.end_of_text) return;
         res = '0;
         if (!bad_text && got_char && !after_dot && digit_cnt != 2'd0 &&
             dot_cnt == DOTS_NEEDED && field_val <= FIELD_MAX) begin
            res.address_ok    = 1'b1;
            res.address_value = {addr_acc[23:0], field_val[7:0]};
            inv = ~res.address_value;
            // Contiguous ones from the top with at least one of them means bit 31 is set.
            if ((inv & (inv + 32'd1)) == 32'd0 && res.address_value[31]) begin
               res.mask_ok     = 1'b1;
               res.prefix_bits = 6'($countones(res.address_value));
            end
         end
         pending_q.insert(pending_q.size(), res);
         restart();
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         results++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with none expected: ok=%0d addr=%h mask=%0d prefix=%0d",
                        got.address_ok, got.address_value, got.mask_ok, got.prefix_bits);
            return;
         end
         want = pending_q.pop_front();
         if (want.address_ok) good_addresses++;
         if (want.mask_ok) good_masks++;
         if (got.address_ok !== want.address_ok || got.address_value !== want.address_value ||
             got.mask_ok !== want.mask_ok || got.prefix_bits !== want.prefix_bits) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: expected ok=%0d addr=%h mask=%0d prefix=%0d, ",
                         "got ok=%0d addr=%h mask=%0d prefix=%0d"},
                        want.address_ok, want.address_value, want.mask_ok, want.prefix_bits,
                        got.address_ok, got.address_value, got.mask_ok, got.prefix_bits);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   quad_scoreboard parser_sb = new();
   logic [7:0]     text_q[$];
   int             items_sent;
   int             strings_sent;
   int             cycle_count;
   int             hold_request;
   int             hold_left;
   bit             idle_on;
   bit             stall_on;

   string directed_texts[] = '{"", "0.0.0.0", "255.255.255.255", "128.0.0.0", "255.0.255.0",
                               "255.255.254.0", "010.001.000.099", "256.1.1.1", "1.1.1.999",
                               "1234.1.1.1", ".1.1.1", "1..1.1", "1.1.1.1.", "1.1.1",
                               "1.1.1.1.1", "1.x.1.1"};

   ipv4_dotted_quad_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !(stall_on && $urandom_range(0, 99) < 15);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) parser_sb.check_response(rsp_data);
         if (req_valid && req_ready) parser_sb.note_request(req_data);
      end
   end

   function automatic void append_char(input logic [7:0] c);
      text_q.insert(text_q.size(), c);
   endfunction

   task automatic send_beat(input req_type beat);
      int gap;
      gap = (idle_on && $urandom_range(0, 99) < 18) ? 1 : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sends the text queue; the string ends either on its last character or on a bare end beat.
   task automatic send_text();
      req_type beat;
      bit      end_on_char;
      int      i;
      end_on_char = text_q.size() != 0 && $urandom_range(0, 1) == 1;
      for (i = 0; i < text_q.size(); i++) begin
         if ($urandom_range(0, 19) == 0) begin
            beat.char_present = 1'b0;
            beat.char_byte    = 8'($urandom_range(0, 255));
            beat.end_of_text  = 1'b0;
            send_beat(beat);
            items_sent++;
         end
         beat.char_present = 1'b1;
         beat.char_byte    = text_q[i];
         beat.end_of_text  = end_on_char && i == text_q.size() - 1;
         send_beat(beat);
         items_sent++;
      end
      if (!end_on_char) begin
         beat.char_present = 1'b0;
         beat.char_byte    = 8'($urandom_range(0, 255));
         beat.end_of_text  = 1'b1;
         send_beat(beat);
         items_sent++;
      end
      strings_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (parser_sb.pending_q.size() != 0);
   endtask

   function automatic logic [7:0] random_octet();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] random_address();
      int          p;
      logic [31:0] a;
      p = $urandom_range(0, 32);
      a = (p == 0) ? 32'd0 : ~32'd0 << (32 - p);
      case ($urandom_range(0, 3))
         0:       return a;
         1:       return a ^ (32'd1 << $urandom_range(0, 31));
         default: return {random_octet(), random_octet(), random_octet(), random_octet()};
      endcase
   endfunction

   // Decimal digits of one field, now and then padded with leading zeros.
   task automatic put_field(input int unsigned v);
      int unsigned nd;
      int          w;
      int          i;
      nd = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(nd, 3) : nd;
      for (i = w - 1; i >= 0; i--)
         append_char(CHAR_ZERO + 8'((v / ((i == 2) ? 100 : (i == 1) ? 10 : 1)) % 10));
   endtask

   task automatic make_quad(input logic [31:0] a);
      int k;
      for (k = 3; k >= 0; k--) begin
         put_field(a[8*k +: 8]);
         if (k != 0) append_char(CHAR_DOT);
      end
   endtask

   task automatic make_dotted(input int n, input flaw_type flaw);
      int f;
      int odd_one;
      odd_one = $urandom_range(0, n - 1);
      for (f = 0; f < n; f++) begin
         if (f > 0) append_char(CHAR_DOT);
         if (f != odd_one || flaw == FLAW_NONE) begin
            put_field(random_octet());
         end else begin
            case (flaw)
               FLAW_OVER_RANGE:  put_field($urandom_range(256, 999));
               FLAW_FOUR_DIGITS: repeat ($urandom_range(4, 5))
                                    append_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
               default: ;
            endcase
         end
      end
   endtask

   task automatic make_broken();
      int idx;
      case ($urandom_range(0, 7))
         0: make_dotted(4, FLAW_OVER_RANGE);
         1: make_dotted(4, FLAW_FOUR_DIGITS);
         2: make_dotted(4, FLAW_EMPTY);
         3: make_dotted($urandom_range(1, 3), FLAW_NONE);
         4: make_dotted(5, FLAW_NONE);
         5: begin
            make_quad(random_address());
            append_char(CHAR_DOT);
         end
         6: begin
            make_quad(random_address());
            text_q.push_front(CHAR_DOT);
         end
         default: begin
            make_quad(random_address());
            idx = $urandom_range(0, text_q.size() - 1);
            if ($urandom_range(0, 1) == 1) text_q[idx] = 8'($urandom_range(0, 255));
            else text_q.delete(idx);
         end
      endcase
   endtask

   task automatic make_noise();
      repeat ($urandom_range(0, 12)) begin
         if ($urandom_range(0, 1) == 1)
            append_char(8'($urandom_range(0, 255)));
         else if ($urandom_range(0, 3) == 0)
            append_char(CHAR_DOT);
         else
            append_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   initial begin
      int  kind;
      int  i;
      int  j;
      bit  hold_done;
      bit  pause_done;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      idle_on      = 1'b1;
      stall_on     = 1'b1;
      hold_request = 0;
      hold_done    = 1'b0;
      pause_done   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < directed_texts.size(); i++) begin
         text_q.delete();
         for (j = 0; j < directed_texts[i].len(); j++) append_char(directed_texts[i][j]);
         send_text();
      end
      text_q = '{8'h00, 8'hFF, CHAR_DOT};
      send_text();

      while (items_sent < ITEM_TARGET) begin
         // A stretch in the middle runs with neither side idling.
         idle_on  = !(items_sent >= 350 && items_sent < 600);
         stall_on = idle_on;
         if (!hold_done && items_sent >= 700) begin
            hold_request = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (!pause_done && items_sent >= 900) begin
            wait_drained();
            pause_done = 1'b1;
         end
         text_q.delete();
         kind = $urandom_range(0, 99);
         if (kind < 65) make_quad(random_address());
         else if (kind < 90) make_broken();
         else make_noise();
         send_text();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d strings in %0d beats; checked %0d results",
               strings_sent, items_sent, parser_sb.results);
      $display("(%0d valid addresses, %0d netmasks). Mismatches: %0d",
               parser_sb.good_addresses, parser_sb.good_masks, parser_sb.mismatches);
      if (parser_sb.mismatches == 0 && parser_sb.pending_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
